// ----- rtl/mmd_pkg.sv -----
// Package for the multipart motion-JPEG deframer: header text tables and shared constants.
package mmd_pkg;

	localparam int LENGTH_BITS_DEF = 24;
	localparam int HEAD_LEN = 30;
	localparam int TAIL_LEN = 30;
	localparam int POS_W = 6;
	localparam int IDX_W = 5;

	typedef logic [POS_W-1:0] pos_t;
	typedef logic [IDX_W-1:0] idx_t;
	typedef logic [7:0] char_t;

	localparam pos_t POS_START = pos_t'(0);
	localparam pos_t POS_ONE = pos_t'(1);
	localparam pos_t POS_TWO = pos_t'(2);
	localparam pos_t POS_DIGITS = pos_t'(HEAD_LEN);
	localparam pos_t POS_TAIL1 = pos_t'(HEAD_LEN + 1);
	localparam pos_t POS_LAST = pos_t'(HEAD_LEN + TAIL_LEN - 1);
	localparam idx_t IDX_TAIL_END = idx_t'(TAIL_LEN - 1);
	localparam idx_t IDX_ZERO = idx_t'(0);

	localparam char_t CH_DASH = 8'h2D;
	localparam char_t CH_ZERO = 8'h30;
	localparam char_t CH_NINE = 8'h39;
	localparam char_t CH_CR = 8'h0D;
	localparam char_t CH_LF = 8'h0A;

	function automatic char_t head_char(input idx_t idx);
		char_t c;
		case (idx)
			5'd0: c = "-";
			5'd1: c = "-";
			5'd2: c = "m";
			5'd3: c = "y";
			5'd4: c = "b";
			5'd5: c = "o";
			5'd6: c = "u";
			5'd7: c = "n";
			5'd8: c = "d";
			5'd9: c = "a";
			5'd10: c = "r";
			5'd11: c = "y";
			5'd12: c = CH_CR;
			5'd13: c = CH_LF;
			5'd14: c = "C";
			5'd15: c = "o";
			5'd16: c = "n";
			5'd17: c = "t";
			5'd18: c = "e";
			5'd19: c = "n";
			5'd20: c = "t";
			5'd21: c = "-";
			5'd22: c = "l";
			5'd23: c = "e";
			5'd24: c = "n";
			5'd25: c = "g";
			5'd26: c = "t";
			5'd27: c = "h";
			5'd28: c = ":";
			5'd29: c = " ";
			default: c = 8'h00;
		endcase
		return c;
	endfunction

	function automatic char_t tail_char(input idx_t idx);
		char_t c;
		case (idx)
			5'd0: c = CH_CR;
			5'd1: c = CH_LF;
			5'd2: c = "C";
			5'd3: c = "o";
			5'd4: c = "n";
			5'd5: c = "t";
			5'd6: c = "e";
			5'd7: c = "n";
			5'd8: c = "t";
			5'd9: c = "-";
			5'd10: c = "t";
			5'd11: c = "y";
			5'd12: c = "p";
			5'd13: c = "e";
			5'd14: c = ":";
			5'd15: c = " ";
			5'd16: c = "i";
			5'd17: c = "m";
			5'd18: c = "a";
			5'd19: c = "g";
			5'd20: c = "e";
			5'd21: c = "/";
			5'd22: c = "j";
			5'd23: c = "p";
			5'd24: c = "e";
			5'd25: c = "g";
			5'd26: c = CH_CR;
			5'd27: c = CH_LF;
			5'd28: c = CH_CR;
			5'd29: c = CH_LF;
			default: c = 8'h00;
		endcase
		return c;
	endfunction

endpackage

// ----- rtl/mjpeg_multipart_deframer.sv -----
// Top level of the multipart motion-JPEG deframer: header search, length decode and payload pass.
// A byte accepted into the input register is decoded into the result register once the output
// side can take it, so a stall on out_ready holds the byte in the input register.
// Throughput is one byte per cycle while out_ready does not stall; each byte needs a character
// compare, a length counter update or both, done between the input register and the result register.
// The asynchronous active-low reset clears the search state, the counters and both valid
// flags, so the block starts searching for a header from the first byte.
module mjpeg_multipart_deframer #(
	parameter int LENGTH_BITS = mmd_pkg::LENGTH_BITS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] in_byte,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_byte,
	output logic       frame_last,
	output logic       frame_empty
);

	localparam int WIDE = LENGTH_BITS + 4;

	logic                   valid_s1;
	logic [7:0]             byte_s1;
	logic                   out_valid_s2;
	logic [7:0]             out_byte_s2;
	logic                   frame_last_s2;
	logic                   frame_empty_s2;

	logic                   in_payload_q;
	mmd_pkg::pos_t          pos_q;
	logic                   digit_seen_q;
	logic [LENGTH_BITS-1:0] alen_q;
	logic [LENGTH_BITS-1:0] rem_q;

	logic                   adv;
	mmd_pkg::pos_t          pos_eff;
	mmd_pkg::idx_t          hidx;
	mmd_pkg::idx_t          tidx;
	logic                   is_dash;
	logic                   is_digit;
	logic [WIDE-1:0]        alen_ext;
	logic [WIDE-1:0]        acc;
	logic [3:0]             digit_val;

	logic                   nxt_payload;
	mmd_pkg::pos_t          nxt_pos;
	logic                   nxt_digit;
	logic [LENGTH_BITS-1:0] nxt_alen;
	logic [LENGTH_BITS-1:0] nxt_rem;
	logic                   res_valid;
	logic [7:0]             res_byte;
	logic                   res_last;
	logic                   res_empty;

	assign adv = valid_s1 && (!out_valid_s2 || out_ready);
	assign in_ready = !valid_s1 || adv;

	assign pos_eff = (pos_q > mmd_pkg::POS_LAST) ? mmd_pkg::POS_START : pos_q;
	assign hidx = pos_eff[mmd_pkg::IDX_W-1:0];
	assign tidx = mmd_pkg::idx_t'(pos_eff - mmd_pkg::POS_DIGITS);
	assign is_dash = (byte_s1 == mmd_pkg::CH_DASH);
	assign is_digit = (byte_s1 >= mmd_pkg::CH_ZERO) && (byte_s1 <= mmd_pkg::CH_NINE);
	assign digit_val = 4'(byte_s1 - mmd_pkg::CH_ZERO);
	assign alen_ext = {4'b0000, alen_q};
	assign acc = (digit_seen_q ? ((alen_ext << 3) + (alen_ext << 1)) : '0)
		+ {{(WIDE-4){1'b0}}, digit_val};

	always_comb begin
		nxt_payload = in_payload_q;
		nxt_pos = pos_eff;
		nxt_digit = digit_seen_q;
		nxt_alen = alen_q;
		nxt_rem = rem_q;
		res_valid = 1'b0;
		res_byte = byte_s1;
		res_last = 1'b0;
		res_empty = 1'b0;
		if (in_payload_q) begin
			nxt_pos = pos_q;
			res_valid = 1'b1;
			res_last = (rem_q <= LENGTH_BITS'(1));
			if (res_last) begin
				nxt_rem = '0;
				nxt_payload = 1'b0;
			end else begin
				nxt_rem = rem_q - LENGTH_BITS'(1);
			end
		end else if (pos_eff < mmd_pkg::POS_DIGITS) begin
			nxt_digit = 1'b0;
			if (byte_s1 == mmd_pkg::head_char(hidx)) begin
				nxt_pos = pos_eff + mmd_pkg::POS_ONE;
			end else if (is_dash) begin
				if ((pos_eff != mmd_pkg::POS_START)
					&& (mmd_pkg::head_char(hidx - mmd_pkg::idx_t'(1)) == mmd_pkg::CH_DASH)) begin
					nxt_pos = mmd_pkg::POS_TWO;
				end else begin
					nxt_pos = mmd_pkg::POS_ONE;
				end
			end else begin
				nxt_pos = mmd_pkg::POS_START;
			end
		end else if (pos_eff == mmd_pkg::POS_DIGITS) begin
			if (is_digit) begin
				nxt_digit = 1'b1;
				if (acc[WIDE-1 -: 4] != 4'b0000) begin
					nxt_alen = '1;
				end else begin
					nxt_alen = acc[LENGTH_BITS-1:0];
				end
			end else if ((byte_s1 == mmd_pkg::tail_char(mmd_pkg::IDX_ZERO)) && digit_seen_q) begin
				nxt_pos = mmd_pkg::POS_TAIL1;
			end else begin
				nxt_digit = 1'b0;
				nxt_pos = is_dash ? mmd_pkg::POS_ONE : mmd_pkg::POS_START;
			end
		end else begin
			if (byte_s1 == mmd_pkg::tail_char(tidx)) begin
				if (tidx == mmd_pkg::IDX_TAIL_END) begin
					nxt_pos = mmd_pkg::POS_START;
					nxt_digit = 1'b0;
					if (alen_q == '0) begin
						res_valid = 1'b1;
						res_byte = 8'h00;
						res_last = 1'b1;
						res_empty = 1'b1;
					end else begin
						nxt_payload = 1'b1;
						nxt_rem = alen_q;
					end
				end else begin
					nxt_pos = pos_eff + mmd_pkg::POS_ONE;
				end
			end else begin
				nxt_digit = 1'b0;
				if (!is_dash) begin
					nxt_pos = mmd_pkg::POS_START;
				end else if (mmd_pkg::tail_char(tidx - mmd_pkg::idx_t'(1)) == mmd_pkg::CH_DASH) begin
					nxt_pos = mmd_pkg::POS_TWO;
				end else begin
					nxt_pos = mmd_pkg::POS_ONE;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= in_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_payload_q <= 1'b0;
			pos_q <= mmd_pkg::POS_START;
			digit_seen_q <= 1'b0;
			alen_q <= '0;
			rem_q <= '0;
			out_valid_s2 <= 1'b0;
		end else if (adv) begin
			in_payload_q <= nxt_payload;
			pos_q <= nxt_pos;
			digit_seen_q <= nxt_digit;
			alen_q <= nxt_alen;
			rem_q <= nxt_rem;
			out_valid_s2 <= res_valid;
		end else if (out_ready) begin
			out_valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && res_valid) begin
			out_byte_s2 <= res_byte;
			frame_last_s2 <= res_last;
			frame_empty_s2 <= res_empty;
		end
	end

	assign out_valid = out_valid_s2;
	assign out_byte = out_byte_s2;
	assign frame_last = frame_last_s2;
	assign frame_empty = frame_empty_s2;

	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= mmd_pkg::POS_LAST)
		else $error("Match position left the header range.");

	a_payload_count: assert property (@(posedge clk) disable iff (!arst_n)
		in_payload_q |-> (rem_q != '0) && (pos_q == mmd_pkg::POS_START) && !digit_seen_q)
		else $error("Payload mode with no bytes left or a live header match.");

	a_digit_pos: assert property (@(posedge clk) disable iff (!arst_n)
		digit_seen_q |-> (pos_q >= mmd_pkg::POS_DIGITS))
		else $error("Length digits flagged outside the length field.");

	a_empty_marker: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && frame_empty) |-> (frame_last && (out_byte == 8'h00)))
		else $error("Empty-frame marker without last flag or with a data byte.");

	a_payload_end: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && in_payload_q && (rem_q == LENGTH_BITS'(1))) |=> (!in_payload_q && frame_last))
		else $error("Final payload byte did not end the frame.");

endmodule
